FILE: rtl/object_depth_query_table_assert.svh
// assertion macros shared by the depth query table rtl
// expects clk_i and rst_ni in the scope of each use
`ifndef OBJECT_DEPTH_QUERY_TABLE_ASSERT_SVH
`define OBJECT_DEPTH_QUERY_TABLE_ASSERT_SVH

// checked property, off while in reset
`define ODQT_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// checked property, live during reset as well
`define ODQT_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) (prop)) else $error(msg);

`endif

FILE: rtl/odqt_pkg.sv
// shared widths, codes, types and the depth decode for the depth query table
// no dependencies
package odqt_pkg;

  localparam int KEY_W   = 32;
  localparam int POS_W   = 12;
  localparam int ZWORD_W = 16;
  localparam int DEPTH_W = 15;
  localparam int PIX_W   = 20;
  localparam int RES_W   = 10;
  localparam int OP_W    = 2;

  // operation codes carried in the input tuser
  localparam logic [OP_W-1:0] OP_REGISTER  = 2'd0;
  localparam logic [OP_W-1:0] OP_FILL      = 2'd1;
  localparam logic [OP_W-1:0] OP_FRAME_END = 2'd2;

  // configuration register indexes
  localparam logic [0:0] REG_IDX_WIDTH  = 1'b0;
  localparam logic [0:0] REG_IDX_HEIGHT = 1'b1;

  localparam logic [RES_W-1:0] WIDTH_RESET  = 10'd320;
  localparam logic [RES_W-1:0] HEIGHT_RESET = 10'd240;

  typedef struct packed {
    logic [PIX_W-1:0] pixel;
    logic             visible;
  } pix_res_t;

  // float z decode tables, indexed by the exponent
  localparam logic [2:0] ZSHIFT [8] = '{3'd6, 3'd5, 3'd4, 3'd3, 3'd2, 3'd1, 3'd0, 3'd0};
  localparam logic [17:0] ZADD [8] = '{
    18'h00000, 18'h20000, 18'h30000, 18'h38000,
    18'h3C000, 18'h3E000, 18'h3F000, 18'h3F800
  };
  localparam logic [10:0] ZMANT_MASK = 11'h7FF;

  function automatic logic [DEPTH_W-1:0] decode_depth(logic [ZWORD_W-1:0] word);
    logic [2:0]  expo;
    logic [10:0] mant;
    logic [17:0] shifted;
    logic [17:0] sum;
    expo    = word[15:13];
    mant    = word[12:2] & ZMANT_MASK;
    shifted = {7'd0, mant} << ZSHIFT[expo];
    sum     = shifted + ZADD[expo];
    return sum[17:3];
  endfunction

endpackage

FILE: rtl/odqt_pixel_unit.sv
// bounds check and pixel index (row times width plus column), one register stage
// depends on odqt_pkg
module odqt_pixel_unit (
  input  logic                            clk_i,
  input  logic [odqt_pkg::POS_W-1:0]      pos_x_i,
  input  logic [odqt_pkg::POS_W-1:0]      pos_y_i,
  input  logic [odqt_pkg::RES_W-1:0]      width_i,
  input  logic [odqt_pkg::RES_W-1:0]      height_i,
  output odqt_pkg::pix_res_t              result_o
);
  import odqt_pkg::*;

  logic             vis;
  logic [PIX_W-1:0] prod;
  logic [PIX_W-1:0] pix;
  pix_res_t         res_q;

  // negative coordinates fail on the sign bit, the rest compares unsigned
  assign vis = !pos_x_i[POS_W-1] && !pos_y_i[POS_W-1] &&
               (pos_x_i[POS_W-2:0] < {1'b0, width_i}) &&
               (pos_y_i[POS_W-2:0] < {1'b0, height_i});

  // y below height keeps it within 10 bits when visible
  assign prod = pos_y_i[RES_W-1:0] * width_i;
  assign pix  = prod + {{(PIX_W-RES_W){1'b0}}, pos_x_i[RES_W-1:0]};

  always_ff @(posedge clk_i) begin
    res_q.visible <= vis;
    res_q.pixel   <= vis ? pix : '0;
  end

  assign result_o = res_q;

endmodule

FILE: rtl/object_depth_query_table.sv
// depth query table: register lookup/append, depth fill, frame swap over two lists
// register item: key scan of the previous list, then the result beat and the append to the current list
// fill, frame end and unused op items each give one result beat; one item at a time, ready only in idle
// the key scan reads one stored entry per cycle and stops at the first hit or the end of the previous list
// async active-low reset: both lists empty, cursor 0, width 320, height 240
// entry memories are not cleared, only entries below the list count are read
module object_depth_query_table #(
  parameter int LIST_DEPTH = 64
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // input stream
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // object_key [31:0], pos_x [43:32], pos_y [55:44], depth_word [71:56]
  input  logic [71:0] s_axis_tdata,
  // operation [1:0]
  input  logic [1:0]  s_axis_tuser,
  // result stream
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // previous_depth [14:0], pixel_index [34:15], zero pad [39:35]
  output logic [39:0] m_axis_tdata,
  // on_screen [0], dropped [1]
  output logic [1:0]  m_axis_tuser,
  // configuration writes
  input  logic        cfg_we_i,
  input  logic [0:0]  cfg_idx_i,
  input  logic [9:0]  cfg_data_i
);
  import odqt_pkg::*;

  localparam int IDX_W     = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1;
  localparam int CNT_W     = $clog2(LIST_DEPTH + 1);
  localparam int ADDR_W    = IDX_W + 1;
  localparam int MEM_DEPTH = 2 ** ADDR_W;
  localparam logic [CNT_W-1:0] LIST_FULL = CNT_W'(LIST_DEPTH);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_REG_DONE,
    ST_FILL_RD,
    ST_FILL_DONE,
    ST_CTRL_DONE
  } state_e;

  state_e state_q;

  // latched input beat
  logic [OP_W-1:0]    op_q;
  logic [KEY_W-1:0]   key_q;
  logic [POS_W-1:0]   x_q;
  logic [POS_W-1:0]   y_q;
  logic [ZWORD_W-1:0] word_q;

  // configuration
  logic [RES_W-1:0] width_q;
  logic [RES_W-1:0] height_q;

  // list bookkeeping
  logic             cur_q;
  logic [CNT_W-1:0] cnt_q [2];
  logic [CNT_W-1:0] cursor_q;

  // scan sequencer
  logic [CNT_W-1:0]   scan_idx_q;
  logic               cmp_vld_q;
  logic               hit_q;
  logic [DEPTH_W-1:0] found_q;
  logic               fill_ok_q;

  // result register
  logic               m_valid_q;
  logic [DEPTH_W-1:0] out_depth_q;
  logic [PIX_W-1:0]   out_pix_q;
  logic               out_vis_q;
  logic               out_drop_q;

  // entry memories, address is {list, entry}
  logic [KEY_W-1:0]   key_mem   [MEM_DEPTH];
  logic [DEPTH_W-1:0] depth_mem [MEM_DEPTH];
  logic [PIX_W:0]     pv_mem    [MEM_DEPTH];   // {visible, pixel}
  logic [KEY_W-1:0]   key_rd_q;
  logic [DEPTH_W-1:0] depth_rd_q;
  logic [PIX_W:0]     pv_rd_q;

  logic [ADDR_W-1:0]  rd_addr;
  logic [ADDR_W-1:0]  wr_addr;
  logic               key_we;
  logic               depth_we;
  logic               pv_we;
  logic [DEPTH_W-1:0] depth_wdata;

  logic               accept;
  logic               out_free;
  logic               res_fire;
  logic [CNT_W-1:0]   n_prev;
  logic [CNT_W-1:0]   n_cur;
  logic               issue;
  logic               has_room;
  logic [DEPTH_W-1:0] fill_depth;
  pix_res_t           pix_res;

  assign accept   = s_axis_tvalid && s_axis_tready;
  assign out_free = !m_valid_q || m_axis_tready;
  // a done state hands its result beat to the output register
  assign res_fire = out_free && (state_q == ST_REG_DONE || state_q == ST_FILL_DONE ||
                                 state_q == ST_CTRL_DONE);
  assign n_prev   = cnt_q[!cur_q];
  assign n_cur    = cnt_q[cur_q];
  assign has_room = n_cur < LIST_FULL;
  // keep issuing reads until the first hit or the end of the previous list
  assign issue    = (state_q == ST_SCAN) && !hit_q && (scan_idx_q < n_prev);

  // fill depth: off-screen entries always store zero
  assign fill_depth = pv_rd_q[PIX_W] ? decode_depth(word_q) : '0;

  odqt_pixel_unit u_pix (
    .clk_i    (clk_i),
    .pos_x_i  (x_q),
    .pos_y_i  (y_q),
    .width_i  (width_q),
    .height_i (height_q),
    .result_o (pix_res)
  );

  // memory addressing and write enables
  always_comb begin
    rd_addr     = (state_q == ST_SCAN) ? {!cur_q, scan_idx_q[IDX_W-1:0]}
                                       : {cur_q, cursor_q[IDX_W-1:0]};
    wr_addr     = {cur_q, cursor_q[IDX_W-1:0]};
    key_we      = 1'b0;
    depth_we    = 1'b0;
    pv_we       = 1'b0;
    depth_wdata = fill_depth;
    if (state_q == ST_REG_DONE && out_free && has_room) begin
      // append: new entry starts with zero depth
      wr_addr     = {cur_q, n_cur[IDX_W-1:0]};
      key_we      = 1'b1;
      depth_we    = 1'b1;
      pv_we       = 1'b1;
      depth_wdata = '0;
    end else if (state_q == ST_FILL_DONE && out_free && fill_ok_q) begin
      depth_we = 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (key_we) begin
      key_mem[wr_addr] <= key_q;
    end
    if (depth_we) begin
      depth_mem[wr_addr] <= depth_wdata;
    end
    if (pv_we) begin
      pv_mem[wr_addr] <= {pix_res.visible, pix_res.pixel};
    end
    key_rd_q   <= key_mem[rd_addr];
    depth_rd_q <= depth_mem[rd_addr];
    pv_rd_q    <= pv_mem[rd_addr];
  end

  // sequencer, bookkeeping and result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      op_q        <= '0;
      key_q       <= '0;
      x_q         <= '0;
      y_q         <= '0;
      word_q      <= '0;
      width_q     <= WIDTH_RESET;
      height_q    <= HEIGHT_RESET;
      cur_q       <= 1'b0;
      cnt_q[0]    <= '0;
      cnt_q[1]    <= '0;
      cursor_q    <= '0;
      scan_idx_q  <= '0;
      cmp_vld_q   <= 1'b0;
      hit_q       <= 1'b0;
      found_q     <= '0;
      fill_ok_q   <= 1'b0;
      m_valid_q   <= 1'b0;
      out_depth_q <= '0;
      out_pix_q   <= '0;
      out_vis_q   <= 1'b0;
      out_drop_q  <= 1'b0;
    end else begin
      if (res_fire) begin
        m_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        m_valid_q <= 1'b0;
      end

      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          REG_IDX_WIDTH:  width_q  <= cfg_data_i;
          REG_IDX_HEIGHT: height_q <= cfg_data_i;
          default: ;
        endcase
      end

      unique case (state_q)
        ST_IDLE: begin
          if (accept) begin
            op_q       <= s_axis_tuser;
            key_q      <= s_axis_tdata[31:0];
            x_q        <= s_axis_tdata[43:32];
            y_q        <= s_axis_tdata[55:44];
            word_q     <= s_axis_tdata[71:56];
            scan_idx_q <= '0;
            cmp_vld_q  <= 1'b0;
            hit_q      <= 1'b0;
            found_q    <= '0;
            unique case (s_axis_tuser)
              OP_REGISTER: state_q <= ST_SCAN;
              OP_FILL:     state_q <= ST_FILL_RD;
              default:     state_q <= ST_CTRL_DONE;
            endcase
          end
        end

        ST_SCAN: begin
          // compare the entry read in the previous cycle, first match wins
          cmp_vld_q <= issue;
          if (issue) begin
            scan_idx_q <= scan_idx_q + 1'b1;
          end
          if (cmp_vld_q && !hit_q && key_rd_q == key_q) begin
            hit_q   <= 1'b1;
            found_q <= depth_rd_q;
          end
          if (hit_q || (!cmp_vld_q && !issue)) begin
            state_q <= ST_REG_DONE;
          end
        end

        ST_REG_DONE: begin
          if (out_free) begin
            out_depth_q <= found_q;
            out_pix_q   <= pix_res.pixel;
            out_vis_q   <= pix_res.visible;
            out_drop_q  <= !has_room;
            if (has_room) begin
              cnt_q[cur_q] <= n_cur + 1'b1;
            end
            state_q <= ST_IDLE;
          end
        end

        ST_FILL_RD: begin
          // entry data for the cursor arrives next cycle
          fill_ok_q <= cursor_q < n_cur;
          state_q   <= ST_FILL_DONE;
        end

        ST_FILL_DONE: begin
          if (out_free) begin
            if (fill_ok_q) begin
              out_depth_q <= fill_depth;
              out_pix_q   <= pv_rd_q[PIX_W-1:0];
              out_vis_q   <= pv_rd_q[PIX_W];
              out_drop_q  <= 1'b0;
              cursor_q    <= cursor_q + 1'b1;
            end else begin
              out_depth_q <= '0;
              out_pix_q   <= '0;
              out_vis_q   <= 1'b0;
              out_drop_q  <= 1'b1;
            end
            state_q <= ST_IDLE;
          end
        end

        ST_CTRL_DONE: begin
          if (out_free) begin
            out_depth_q <= '0;
            out_pix_q   <= '0;
            out_vis_q   <= 1'b0;
            out_drop_q  <= 1'b0;
            // frame end swaps lists and empties the new current one
            if (op_q == OP_FRAME_END) begin
              cur_q         <= !cur_q;
              cnt_q[!cur_q] <= '0;
              cursor_q      <= '0;
            end
            state_q <= ST_IDLE;
          end
        end

        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign s_axis_tready = (state_q == ST_IDLE);
  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = {5'd0, out_pix_q, out_depth_q};
  assign m_axis_tuser  = {out_drop_q, out_vis_q};

  `include "object_depth_query_table_assert.svh"

  `ODQT_ASSERT(a_count_bound,
               (cnt_q[0] <= LIST_FULL) && (cnt_q[1] <= LIST_FULL),
               "list count above depth")
  `ODQT_ASSERT(a_cursor_bound, cursor_q <= cnt_q[cur_q], "fill cursor past current list count")
  `ODQT_ASSERT(a_hit_after_compare,
               $rose(hit_q) |-> $past(cmp_vld_q && state_q == ST_SCAN),
               "hit without a compared entry")
  `ODQT_ASSERT(a_result_source, $rose(m_valid_q) |-> $past(res_fire),
               "result beat outside a done state")
  `ODQT_ASSERT_ALWAYS(a_reset_quiet, !rst_ni |-> !m_axis_tvalid, "result valid during reset")

endmodule

FILE: dv/tb.sv
// self-checking testbench for object_depth_query_table: stream driver, result monitor
// and a predictor of both ping-pong lists; depends on rtl/odqt_pkg.sv and the rtl top
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import odqt_pkg::*;

  localparam int LIST_DEPTH   = 64;
  localparam int HOLD_CYCLES  = 300;              // long receiver hold-off
  localparam int DRAIN_CYCLES = LIST_DEPTH + 16;  // longest key scan plus margin
  localparam int CYCLE_LIMIT  = 600000;

  // unused operation code, the block must ignore it
  localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

  // offsets of the float z decode form a ladder: span minus span >> exponent
  localparam int unsigned Z_SPAN = 32'h40000;

  // one input beat, fields as the block sees them
  typedef struct packed {
    logic [OP_W-1:0]    op;
    logic [KEY_W-1:0]   key;
    logic [POS_W-1:0]   pos_x;
    logic [POS_W-1:0]   pos_y;
    logic [ZWORD_W-1:0] zword;
  } query_t;

  // one result beat
  typedef struct packed {
    logic [DEPTH_W-1:0] depth;
    logic [PIX_W-1:0]   pixel;
    logic               on_screen;
    logic               dropped;
  } reply_t;

  logic        clk_i         = 1'b0;
  logic        rst_ni        = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [71:0] s_axis_tdata  = '0;  // object_key, pos_x, pos_y, depth_word (lsb up)
  logic [1:0]  s_axis_tuser  = '0;  // operation
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [39:0] m_axis_tdata;        // previous_depth, pixel_index, zero pad (lsb up)
  logic [1:0]  m_axis_tuser;        // on_screen, dropped (lsb up)
  logic        cfg_we_i      = 1'b0;
  logic [0:0]  cfg_idx_i     = '0;
  logic [9:0]  cfg_data_i    = '0;

  // stimulus and scoreboard
  query_t query_q[$];
  reply_t reply_q[$];
  query_t next_q;
  query_t taken;
  reply_t got;
  logic   beat_taken = 1'b0;
  int     err_cnt    = 0;
  int     stim_cnt   = 0;
  int     cycle_cnt  = 0;

  // idling knobs and the receiver hold-off
  int     send_idle_pct  = 0;
  int     recv_stall_pct = 0;
  logic   hold_ask       = 1'b0;
  logic   hold_done      = 1'b0;
  int     hold_left      = 0;

  // predictor state: two lists, live list select, fill cursor, resolution
  logic [KEY_W-1:0]   row_key   [2][LIST_DEPTH];
  logic [DEPTH_W-1:0] row_depth [2][LIST_DEPTH];
  logic [PIX_W-1:0]   row_pixel [2][LIST_DEPTH];
  logic               row_vis   [2][LIST_DEPTH];
  int unsigned        row_cnt   [2] = '{0, 0};
  logic               live_list = 1'b0;
  int unsigned        fill_ptr  = 0;
  logic [RES_W-1:0]   scr_w     = WIDTH_RESET;
  logic [RES_W-1:0]   scr_h     = HEIGHT_RESET;

  // keys of the frame being built and of the one before, for lookup hits
  logic [KEY_W-1:0] prev_keys[$];
  logic [KEY_W-1:0] cur_keys[$];

  object_depth_query_table #(
    .LIST_DEPTH(LIST_DEPTH)
  ) i_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_data_i   (cfg_data_i)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // 16-bit float z word to 15-bit integer depth
  function automatic logic [DEPTH_W-1:0] zword_to_depth(logic [ZWORD_W-1:0] w);
    int unsigned expo;
    int unsigned mant;
    int unsigned sh;
    int unsigned sum;
    expo = w[15:13];
    mant = w[12:2];
    sh   = (expo == 7) ? 0 : 6 - expo;
    sum  = (mant << sh) + (Z_SPAN - (Z_SPAN >> expo));
    return DEPTH_W'(sum >> 3);
  endfunction

  // expected result of one accepted beat, advances the list state
  function automatic reply_t depth_reply(query_t q);
    reply_t      r;
    logic        cur;
    logic        prv;
    int          x;
    int          y;
    int unsigned k;
    r   = '0;
    cur = live_list;
    prv = ~live_list;
    x   = $signed(q.pos_x);
    y   = $signed(q.pos_y);
    case (q.op)
      OP_REGISTER: begin
        // first match in last frame's list wins
        for (k = 0; k < row_cnt[prv]; k++) begin
          if (row_key[prv][k] == q.key) begin
            r.depth = row_depth[prv][k];
            break;
          end
        end
        // a zero width or height leaves nothing on screen
        if (x >= 0 && x < int'(scr_w) && y >= 0 && y < int'(scr_h)) begin
          r.on_screen = 1'b1;
          r.pixel     = PIX_W'(y * int'(scr_w) + x);
        end
        if (row_cnt[cur] < LIST_DEPTH) begin
          k                 = row_cnt[cur];
          row_key[cur][k]   = q.key;
          row_depth[cur][k] = '0;
          row_pixel[cur][k] = r.pixel;
          row_vis[cur][k]   = r.on_screen;
          row_cnt[cur]++;
        end else begin
          r.dropped = 1'b1;  // list full, lookup still reported
        end
      end
      OP_FILL: begin
        if (fill_ptr < row_cnt[cur]) begin
          k                 = fill_ptr;
          // off-screen entries keep depth 0 whatever the word
          r.depth           = row_vis[cur][k] ? zword_to_depth(q.zword) : '0;
          row_depth[cur][k] = r.depth;
          r.pixel           = row_pixel[cur][k];
          r.on_screen       = row_vis[cur][k];
          fill_ptr++;
        end else begin
          r.dropped = 1'b1;  // fill past the last registered entry
        end
      end
      OP_FRAME_END: begin
        live_list    = prv;
        row_cnt[prv] = 0;
        fill_ptr     = 0;
      end
      default: ;  // unused code, no state change
    endcase
    return r;
  endfunction

  task automatic check_reply(reply_t g);
    reply_t want;
    if (reply_q.size() == 0) begin
      err_cnt++;
      if (err_cnt <= 10)
        $display("unexpected result: depth %0d pixel %0d on_screen %0b dropped %0b",
                 g.depth, g.pixel, g.on_screen, g.dropped);
    end else begin
      want = reply_q.pop_front();
      if (g.depth !== want.depth || g.pixel !== want.pixel ||
          g.on_screen !== want.on_screen || g.dropped !== want.dropped) begin
        err_cnt++;
        if (err_cnt <= 10)
          $display("mismatch: expected depth %0d pixel %0d on %0b drop %0b, %s %0d %0d %0b %0b",
                   want.depth, want.pixel, want.on_screen, want.dropped, "got",
                   g.depth, g.pixel, g.on_screen, g.dropped);
      end
    end
  endtask

  // input driver: a new beat only once the held one was taken
  always @(negedge clk_i) begin
    if (rst_ni && (!s_axis_tvalid || beat_taken)) begin
      if (query_q.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
        next_q = query_q.pop_front();
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {next_q.zword, next_q.pos_y, next_q.pos_x, next_q.key};
        s_axis_tuser  <= next_q.op;
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
    beat_taken <= 1'b0;
  end

  // receiver ready: random stalls, plus one long hold-off that backs up the input
  always @(negedge clk_i) begin
    if (hold_left != 0) begin
      m_axis_tready <= 1'b0;
      hold_left     <= hold_left - 1;
    end else if (hold_ask && !hold_done) begin
      m_axis_tready <= 1'b0;
      hold_left     <= HOLD_CYCLES;
      hold_done     <= 1'b1;
    end else begin
      m_axis_tready <= rst_ni && ($urandom_range(0, 99) >= recv_stall_pct);
    end
  end

  // monitor: check results, predict on every accepted input beat
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) begin
        got = {m_axis_tdata[14:0], m_axis_tdata[34:15], m_axis_tuser[0], m_axis_tuser[1]};
        check_reply(got);
      end
      if (s_axis_tvalid && s_axis_tready) begin
        taken = {s_axis_tuser, s_axis_tdata[31:0], s_axis_tdata[43:32],
                 s_axis_tdata[55:44], s_axis_tdata[71:56]};
        reply_q.push_back(depth_reply(taken));
        beat_taken <= 1'b1;
      end
    end
  end

  // watchdog
  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  task automatic push_query(logic [OP_W-1:0] op, logic [KEY_W-1:0] key, int x, int y,
                            logic [ZWORD_W-1:0] zw);
    query_t q;
    q.op    = op;
    q.key   = key;
    q.pos_x = POS_W'(x);
    q.pos_y = POS_W'(y);
    q.zword = zw;
    query_q.push_back(q);
    if (op != OP_UNUSED)
      stim_cnt++;
  endtask

  // wait until every beat is in and every result out, then let the block settle
  task automatic drain();
    while (query_q.size() != 0 || s_axis_tvalid || reply_q.size() != 0)
      @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(negedge clk_i);
  endtask

  task automatic write_reg(logic [0:0] idx, logic [RES_W-1:0] val);
    @(negedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val;
    if (idx == REG_IDX_WIDTH)
      scr_w = val;
    else
      scr_h = val;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  // mostly from 0 up to the limit, sometimes the last row or column, sometimes anywhere in the 12-bit range
  function automatic int pick_coord(int lim);
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4, 5: return $urandom_range(0, lim);
      6:                return lim - 1;
      default:          return $signed(POS_W'($urandom()));
    endcase
  endfunction

  // one frame: registrations, fills around the registered count, frame end;
  // occasional unused-code beats and stray fills mixed in
  task automatic queue_frame(bit big);
    int               n_reg;
    int               n_fill;
    int               i;
    logic [KEY_W-1:0] key;
    n_reg  = (big || $urandom_range(0, 99) < 8) ? $urandom_range(62, 68)
                                                 : $urandom_range(0, 8);
    n_fill = n_reg + $urandom_range(0, 4) - 2;
    if (n_fill < 0)
      n_fill = 0;
    for (i = 0; i < n_reg; i++) begin
      if ($urandom_range(0, 99) < 8)
        push_query($urandom_range(0, 1) ? OP_UNUSED : OP_FILL, $urandom(),
                   pick_coord(scr_w), pick_coord(scr_h), $urandom());
      if (prev_keys.size() != 0 && $urandom_range(0, 1))
        key = prev_keys[$urandom_range(0, prev_keys.size() - 1)];
      else
        key = $urandom();
      cur_keys.push_back(key);
      push_query(OP_REGISTER, key, pick_coord(scr_w), pick_coord(scr_h), $urandom());
    end
    for (i = 0; i < n_fill; i++)
      push_query(OP_FILL, $urandom(), pick_coord(scr_w), pick_coord(scr_h), $urandom());
    push_query(OP_FRAME_END, $urandom(), pick_coord(scr_w), pick_coord(scr_h), $urandom());
    prev_keys = cur_keys;
    cur_keys.delete();
  endtask

  // resolution change while idle, then random frames under the given idling
  task automatic run_phase(logic [RES_W-1:0] w, logic [RES_W-1:0] h, int send_pct,
                           int recv_pct, int n_items, bit pressure);
    int target;
    drain();
    write_reg(REG_IDX_WIDTH, w);
    write_reg(REG_IDX_HEIGHT, h);
    send_idle_pct  = send_pct;
    recv_stall_pct = recv_pct;
    target         = stim_cnt + n_items;
    // a pressure phase opens with a frame of 62 to 68 registrations so the hold-off meets a busy input
    queue_frame(pressure);
    while (stim_cnt < target)
      queue_frame(1'b0);
    if (pressure)
      hold_ask = 1'b1;
  endtask

  initial begin
    // reset edge after time zero so the asynchronous reset is seen
    #1 rst_ni = 1'b0;
    repeat (4) @(negedge clk_i);
    rst_ni <= 1'b1;

    // directed part under the reset resolution 320 x 240
    push_query(OP_FILL, 32'h0000_0000, 0, 0, 16'h1234);          // nothing to fill yet
    push_query(OP_REGISTER, 32'h0000_0000, 0, 0, 16'h0000);
    push_query(OP_REGISTER, 32'hFFFF_FFFF, 319, 239, 16'hFFFF);  // last pixel
    push_query(OP_REGISTER, 32'h1234_5678, -2048, -2048, 16'h0000);
    push_query(OP_REGISTER, 32'hA5A5_A5A5, 2047, 2047, 16'hFFFF);
    push_query(OP_REGISTER, 32'h5A5A_5A5A, 320, 10, 16'h0000);   // x on the width
    push_query(OP_REGISTER, 32'h0000_FFFF, 10, 240, 16'h0000);   // y on the height
    push_query(OP_REGISTER, 32'h0000_0000, 100, -1, 16'h0000);   // duplicate key
    push_query(OP_REGISTER, 32'h8000_0001, 160, 120, 16'h0000);
    push_query(OP_FILL, 32'h0, 0, 0, 16'h1FFC);                  // lowest exponent
    push_query(OP_FILL, 32'h0, 0, 0, 16'hFFFF);                  // highest exponent
    push_query(OP_FILL, 32'h0, 0, 0, 16'h3FFF);                  // off-screen entry
    push_query(OP_FILL, 32'h0, 0, 0, 16'h5555);
    push_query(OP_FILL, 32'h0, 0, 0, 16'h9AAA);
    push_query(OP_FILL, 32'h0, 0, 0, 16'hBFFC);
    push_query(OP_FILL, 32'h0, 0, 0, 16'hDFFF);
    push_query(OP_FILL, 32'h0, 0, 0, 16'h7FFF);
    push_query(OP_FILL, 32'h0, 0, 0, 16'hFFFF);                  // past the end
    push_query(OP_UNUSED, 32'hFFFF_FFFF, -1, -1, 16'hFFFF);
    push_query(OP_FRAME_END, 32'h0, 0, 0, 16'h0000);
    push_query(OP_REGISTER, 32'h0000_0000, 5, 5, 16'h0000);      // first match wins
    push_query(OP_REGISTER, 32'hFFFF_FFFF, 6, 6, 16'h0000);
    push_query(OP_REGISTER, 32'h8000_0001, 7, 7, 16'h0000);
    push_query(OP_REGISTER, 32'hDEAD_BEEF, 8, 8, 16'h0000);      // absent key

    // random part, one idling style per phase
    run_phase(10'd1023, 10'd1023, 0, 0, 90, 1'b1);
    run_phase(10'd1, 10'd1, 46, 0, 80, 1'b0);
    run_phase(10'd0, 10'd700, 0, 46, 80, 1'b0);     // zero width
    run_phase(10'd640, 10'd0, 23, 23, 80, 1'b0);    // zero height
    run_phase(10'd17, 10'd9, 0, 0, 80, 1'b0);
    run_phase(10'd1023, 10'd1, 23, 23, 90, 1'b0);

    drain();
    if (err_cnt == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
